### src/trie_pkg.sv
// Shared constants and types for the trie dictionary block.
// No dependencies; imported by trie_insert_and_first_lookup_top.
package trie_pkg;

  localparam int unsigned NODE_COUNT    = 4096;
  localparam int unsigned ALPHABET_SIZE = 26;

  localparam int unsigned NodeW   = $clog2(NODE_COUNT);
  localparam int unsigned LetterW = 5;
  localparam int unsigned LetIdxW = $clog2(ALPHABET_SIZE);
  localparam int unsigned StatusW = 3;

  // One memory row per node: all child links, then word-end and seen marks.
  localparam int unsigned LinksW  = ALPHABET_SIZE * NodeW;
  localparam int unsigned RowW    = LinksW + 2;
  localparam int unsigned EndBit  = LinksW;
  localparam int unsigned SeenBit = LinksW + 1;

  localparam logic [NodeW-1:0] NodeLast = NodeW'(NODE_COUNT - 1);

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_REPEAT   = 3'd1,
    ST_WRONG    = 3'd2,
    ST_INSERTED = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

endpackage

### src/trie_insert_and_first_lookup_top.sv
// Trie dictionary with word insert and first-hit lookup, one letter per request.
// Depends on trie_pkg and trie_ram.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one letter request: mode_i
//   (0 insert, 1 query), letter_i (a=0 .. z=25) and word_last_i on the final
//   letter. Output channel (out_valid_o/out_ready_i) carries one status per
//   word, issued for its last letter: ok, repeat, wrong, inserted, table full.
// Storage:
//   One RAM row per node holds the 26 child links plus word-end and seen
//   marks. Each letter is a read-modify-write of the current node's row.
// Timing:
//   A letter that is not last is accepted, then walked with the row read back.
//   A last letter goes through accept, walk, read of the end node's row, then
//   mark update; the status is registered and shows on out_valid_o the cycle
//   after. The registered RAM read between the current node and its child
//   sets these steps.
// Reset:
//   rst_ni clears control state, then a clearing pass writes every node row
//   to zero, with in_ready_o low throughout.
// Stall:
//   A pending status waits in the output register while the next letters are
//   accepted and walked; only the final mark step of the following word holds
//   until the output register is free.
module trie_insert_and_first_lookup_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [trie_pkg::LetterW-1:0]  letter_i,
  input  logic                          word_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [trie_pkg::StatusW-1:0]  status_o
);
  import trie_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_READ,
    S_FIN
  } state_e;

  state_e               state_q, state_d;
  logic [NodeW-1:0]     clr_q, clr_d;
  logic [NodeW-1:0]     cur_q, cur_d;
  logic [NodeW-1:0]     used_q, used_d;
  logic                 failed_q, failed_d;
  logic                 mode_q, mode_d;
  logic [LetterW-1:0]   letter_q, letter_d;
  logic                 last_q, last_d;
  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;

  // RAM port signals
  logic                 ram_we;
  logic [NodeW-1:0]     ram_waddr;
  logic [RowW-1:0]      ram_wdata;
  logic                 ram_re;
  logic [NodeW-1:0]     ram_raddr;
  logic [RowW-1:0]      row_rd;

  logic [LetIdxW-1:0]   let_idx;
  logic                 let_ok;
  logic [NodeW-1:0]     link_rd;
  logic [NodeW-1:0]     used_inc;
  logic                 link_hit;

  trie_ram #(
    .Width(RowW),
    .Depth(NODE_COUNT)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(row_rd)
  );

  assign let_idx  = LetIdxW'(letter_q);
  assign let_ok   = (32'(letter_q) < ALPHABET_SIZE);
  assign link_rd  = row_rd[let_idx*NodeW +: NodeW];
  assign used_inc = used_q + 1'b1;
  // zero means no child; anything outside the pool is treated the same
  assign link_hit = (link_rd != '0) && (32'(link_rd) < NODE_COUNT);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    used_d      = used_q;
    failed_d    = failed_q;
    mode_d      = mode_q;
    letter_d    = letter_q;
    last_d      = last_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = cur_q;
    ram_wdata   = row_rd;
    ram_re      = 1'b0;
    ram_raddr   = cur_q;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == NodeLast) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          mode_d   = mode_i;
          letter_d = letter_i;
          last_d   = word_last_i;
          ram_re   = 1'b1;
          state_d  = S_WALK;
        end
      end

      S_WALK: begin
        // row_rd holds the current node's row
        if (!failed_q && let_ok) begin
          if (link_hit) begin
            cur_d = link_rd;
          end else if (mode_q) begin
            failed_d = 1'b1;
          end else if (used_q == NodeLast) begin
            failed_d = 1'b1;
          end else begin
            used_d    = used_inc;
            cur_d     = used_inc;
            ram_we    = 1'b1;
            ram_wdata[let_idx*NodeW +: NodeW] = used_inc;
          end
        end
        state_d = last_q ? S_READ : S_IDLE;
      end

      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_FIN;
      end

      S_FIN: begin
        // row_rd holds the end node's row; wait for a free output register
        if (!out_valid_q || out_ready_i) begin
          if (!mode_q) begin
            if (failed_q) begin
              status_d = ST_FULL;
            end else begin
              ram_we             = 1'b1;
              ram_wdata[EndBit]  = 1'b1;
              status_d           = ST_INSERTED;
            end
          end else if (failed_q || !row_rd[EndBit]) begin
            status_d = ST_WRONG;
          end else if (!row_rd[SeenBit]) begin
            ram_we             = 1'b1;
            ram_wdata[SeenBit] = 1'b1;
            status_d           = ST_OK;
          end else begin
            status_d = ST_REPEAT;
          end
          out_valid_d = 1'b1;
          cur_d       = '0;
          failed_d    = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cur_q       <= '0;
      used_q      <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_q       <= cur_d;
      used_q      <= used_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    letter_q <= letter_d;
    last_q   <= last_d;
    status_q <= status_d;
  end

  // The node counter only grows.
  a_used_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (used_q >= $past(used_q)))
    else $error("node counter decreased");

  // The walk never points past the last allocated node.
  a_cur_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= used_q)
    else $error("current node beyond allocated pool");

  // A status appears only from the mark step.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("status issued outside mark step");

  // An accepted letter blocks the input until its walk is done.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request accepted during walk");

  // The RAM is not written while waiting for a request.
  a_idle_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("row write while idle");

endmodule

### src/trie_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module trie_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
